@@ sv/trcs_pkg.sv @@
// shared types and constants for the tile run coalesce/split block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package trcs_pkg;

  // field widths of the input and result transactions
  localparam int TILE_W       = 12;
  localparam int COUNT_W      = 5;
  localparam int CHUNK_TILE_W = 13;

  // default configuration
  localparam int CHUNK_MAX_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // chunk slots of one entry record, in output order
  localparam int SLOTS      = 3;
  localparam int SLOT_FLUSH = 0;  // remainder of a broken run
  localparam int SLOT_FULL  = 1;  // completed full chunk
  localparam int SLOT_FEND  = 2;  // remainder at frame end

  // input transaction
  typedef struct packed {
    logic [TILE_W-1:0]  tile_start;
    logic [COUNT_W-1:0] tile_count;
    logic               frame_end;
  } trcs_in_t;

  // result transaction
  typedef struct packed {
    logic [CHUNK_TILE_W-1:0] chunk_tile;
    logic [COUNT_W-1:0]      chunk_count;
    logic                    last_of_item;
    logic                    frame_done;
  } trcs_out_t;

  // one chunk as classified by the front end
  typedef struct packed {
    logic                    valid;
    logic [CHUNK_TILE_W-1:0] tile;
    logic [COUNT_W-1:0]      count;
  } trcs_slot_t;

  // everything one accepted entry produces
  typedef struct packed {
    logic                        frame_end;
    trcs_slot_t [SLOTS-1:0]      slot;
  } trcs_rec_t;

endpackage

@@ sv/trcs_front.sv @@
// front end: run tracking and classification of each entry into chunk slots
// depends on trcs_pkg
`timescale 1ns / 1ps

module trcs_front import trcs_pkg::*; #(
  parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  trcs_in_t  item_i,
  output logic      rec_valid_o,
  output trcs_rec_t rec_o
);

  localparam logic [COUNT_W-1:0]      CHUNK_C      = COUNT_W'(CHUNK_MAX);
  localparam logic [CHUNK_TILE_W-1:0] CHUNK_TILE_C = CHUNK_TILE_W'(CHUNK_MAX);

  logic                    run_open_q, run_open_d;
  logic [CHUNK_TILE_W-1:0] run_start_q, run_start_d;
  logic [COUNT_W-1:0]      run_size_q, run_size_d;

  logic [COUNT_W-1:0]      cnt;
  logic [CHUNK_TILE_W-1:0] tile_ext;
  logic [CHUNK_TILE_W-1:0] run_end;
  logic                    brk;
  logic                    restart;
  logic [CHUNK_TILE_W-1:0] base_start;
  logic [COUNT_W-1:0]      base_size;
  logic [COUNT_W-1:0]      sum;
  logic                    full_hit;
  logic [CHUNK_TILE_W-1:0] rem_start;
  logic [COUNT_W-1:0]      rem_size;

  // saturate count and test contiguity against the open run
  always_comb begin
    cnt        = (item_i.tile_count > CHUNK_C) ? CHUNK_C : item_i.tile_count;
    tile_ext   = CHUNK_TILE_W'(item_i.tile_start);
    run_end    = run_start_q + CHUNK_TILE_W'(run_size_q);
    brk        = run_open_q && (tile_ext != run_end);
    restart    = !run_open_q || brk;
    base_start = restart ? tile_ext : run_start_q;
    base_size  = restart ? '0 : run_size_q;
    sum        = base_size + cnt;
    full_hit   = (sum >= CHUNK_C);
    rem_start  = full_hit ? (base_start + CHUNK_TILE_C) : base_start;
    rem_size   = full_hit ? (sum - CHUNK_C) : sum;
  end

  // fill the record slots
  always_comb begin
    rec_o.frame_end               = item_i.frame_end;
    rec_o.slot[SLOT_FLUSH].valid  = brk && (run_size_q != '0);
    rec_o.slot[SLOT_FLUSH].tile   = run_start_q;
    rec_o.slot[SLOT_FLUSH].count  = run_size_q;
    rec_o.slot[SLOT_FULL].valid   = full_hit;
    rec_o.slot[SLOT_FULL].tile    = base_start;
    rec_o.slot[SLOT_FULL].count   = CHUNK_C;
    rec_o.slot[SLOT_FEND].valid   = item_i.frame_end && (rem_size != '0);
    rec_o.slot[SLOT_FEND].tile    = rem_start;
    rec_o.slot[SLOT_FEND].count   = rem_size;
    rec_valid_o = accept_i && (rec_o.slot[SLOT_FLUSH].valid || rec_o.slot[SLOT_FULL].valid ||
                               rec_o.slot[SLOT_FEND].valid);
  end

  // next run state; frame end closes and clears the run
  always_comb begin
    run_open_d  = run_open_q;
    run_start_d = run_start_q;
    run_size_d  = run_size_q;
    if (accept_i) begin
      if (item_i.frame_end) begin
        run_open_d  = 1'b0;
        run_start_d = '0;
        run_size_d  = '0;
      end else begin
        run_open_d  = 1'b1;
        run_start_d = rem_start;
        run_size_d  = rem_size;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q  <= 1'b0;
      run_start_q <= '0;
      run_size_q  <= '0;
    end else begin
      run_open_q  <= run_open_d;
      run_start_q <= run_start_d;
      run_size_q  <= run_size_d;
    end
  end

endmodule

@@ sv/trcs_queue.sv @@
// small record queue between front end and back end
// depends on trcs_pkg
`timescale 1ns / 1ps

module trcs_queue import trcs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  trcs_rec_t rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output trcs_rec_t rec_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  trcs_rec_t        store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == DEPTH_C);
  assign empty_o = (fill_q == '0);
  assign rec_o   = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // record storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

@@ sv/trcs_back.sv @@
// back end: serializes the chunk slots of each record into the output register
// depends on trcs_pkg
`timescale 1ns / 1ps

module trcs_back import trcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rec_empty_i,
  input  trcs_rec_t rec_i,
  output logic      rec_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output trcs_out_t item_o
);

  logic [SLOTS-1:0] done_q, done_d;
  logic             out_valid_q, out_valid_d;
  trcs_out_t        out_q, out_d;

  logic [SLOTS-1:0] avail;
  logic [SLOTS-1:0] rest;
  logic [SLOTS-1:0] pick;
  logic             last;
  logic             load;
  trcs_slot_t       sel;

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

  // pick the oldest pending slot of the head record
  always_comb begin
    avail = '0;
    for (int i = 0; i < SLOTS; i++) begin
      avail[i] = rec_i.slot[i].valid;
    end
    avail = avail & ~done_q;
    rest  = avail & (avail - 1'b1);
    pick  = avail & ~rest;
    last  = (rest == '0);
    sel   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick[i]) begin
        sel = sel | rec_i.slot[i];
      end
    end
  end

  // load the output register when a record is waiting and the register is free or being drained
  always_comb begin
    load        = !rec_empty_i && (!out_valid_q || pop_i);
    rec_pop_o   = load && last;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d        = 1'b1;
      out_d.chunk_tile   = sel.tile;
      out_d.chunk_count  = sel.count;
      out_d.last_of_item = last;
      out_d.frame_done   = last && rec_i.frame_end;
      done_d             = last ? '0 : (done_q | pick);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

@@ sv/tile_run_coalesce_split.sv @@
// top level of the tile run coalesce/split block
// depends on trcs_pkg, trcs_front, trcs_queue, trcs_back
`timescale 1ns / 1ps

// Merges a frame's tile-load entries into contiguous runs and gives them out
// as chunks of at most CHUNK_MAX tiles. An entry is taken in every cycle that
// full is low; the front end classifies it in that cycle and, when the entry
// yields any chunk, writes one record into a QUEUE_DEPTH-entry queue. The back
// end emits one chunk per cycle into the output register while pop is high, and
// an entry yields 0 to 3 chunks, each a separate result transaction: the
// sustained rate is one entry per cycle as long as entries average at most
// one chunk, and the queue absorbs short bursts. A chunk passes through the
// record queue and then the output register before it reaches the result port.
module tile_run_coalesce_split import trcs_pkg::*; #(
  parameter int CHUNK_MAX   = CHUNK_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  trcs_in_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output trcs_out_t out_item_o
);

  logic      accept;
  logic      rec_push;
  trcs_rec_t rec_in;
  logic      rec_pop;
  logic      rec_empty;
  trcs_rec_t rec_head;

  // a transaction enters when the record queue has room
  assign accept = push && !full;

  trcs_front #(
    .CHUNK_MAX (CHUNK_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .rec_valid_o (rec_push),
    .rec_o       (rec_in)
  );

  trcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .empty_o (rec_empty),
    .rec_o   (rec_head)
  );

  trcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (rec_head),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule

@@ tb/tb.sv @@
// self-checking testbench for tile_run_coalesce_split
// depends on trcs_pkg and the tile_run_coalesce_split rtl; a directed table, then random frames
`timescale 1ns / 1ps

module tb;
  import trcs_pkg::*;

  localparam int CHUNK_TILES    = CHUNK_MAX_DEF;
  localparam int RANDOM_ENTRIES = 480;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 16;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_AT        = 120;
  localparam int HOLD_CYCLES    = 64;
  localparam int MAX_REPORTS    = 10;

  // one row of the directed table; typed rows carry their chunks written out
  typedef struct packed {
    trcs_in_t              entry;
    logic                  typed;
    logic [1:0]            n_typed;
    trcs_out_t [1:0]       typed_chunk;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  trcs_in_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  trcs_out_t out_item;

  // predictor state
  logic                    run_open;
  logic [CHUNK_TILE_W-1:0] run_start;
  logic [COUNT_W-1:0]      run_size;

  trcs_out_t expected_chunks[$];
  int        stream_tile = 0;
  int        mismatches = 0;
  int        entries_sent = 0;
  int        chunks_checked = 0;
  int        frame_ends = 0;
  int        full_stalls = 0;
  int        feed_left = 0;
  bit        feed_steady = 1'b0;

  tile_run_coalesce_split dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always #1 clk_i = ~clk_i;

  function automatic trcs_out_t mk_chunk(int tile, int count, bit last, bit done);
    trcs_out_t c;
    c.chunk_tile   = CHUNK_TILE_W'(tile);
    c.chunk_count  = COUNT_W'(count);
    c.last_of_item = last;
    c.frame_done   = done;
    return c;
  endfunction

  // n < 0 leaves the row to the predictor
  function automatic dir_row_t mk_row(int tile, int count, bit fend, int n,
                                      trcs_out_t c0, trcs_out_t c1);
    dir_row_t r;
    r.entry.tile_start = TILE_W'(tile);
    r.entry.tile_count = COUNT_W'(count);
    r.entry.frame_end  = fend;
    r.typed            = (n >= 0);
    r.n_typed          = (n >= 0) ? 2'(n) : 2'd0;
    r.typed_chunk[0]   = c0;
    r.typed_chunk[1]   = c1;
    return r;
  endfunction

  // merge one entry into the open run and split off the chunks it completes
  function automatic int coalesce_entry(input trcs_in_t e, output trcs_out_t [2:0] res);
    logic [COUNT_W-1:0]    cnt;
    logic [CHUNK_TILE_W:0] run_end;
    int                    n;
    n   = 0;
    res = '0;
    cnt = (e.tile_count > CHUNK_TILES) ? COUNT_W'(CHUNK_TILES) : e.tile_count;
    run_end = {1'b0, run_start} + run_size;
    // contiguity break flushes the remainder, compare does not wrap
    if (run_open && {2'b00, e.tile_start} != run_end) begin
      if (run_size != 0) begin
        res[n] = mk_chunk(run_start, run_size, 1'b0, 1'b0);
        n++;
      end
      run_open = 1'b0;
    end
    if (!run_open) begin
      run_open  = 1'b1;
      run_start = {1'b0, e.tile_start};
      run_size  = '0;
    end
    // full chunk leaves as soon as it is gathered
    run_size = run_size + cnt;
    if (run_size >= CHUNK_TILES) begin
      res[n] = mk_chunk(run_start, CHUNK_TILES, 1'b0, 1'b0);
      n++;
      run_start = CHUNK_TILE_W'(run_start + CHUNK_TILES);
      run_size  = COUNT_W'(run_size - CHUNK_TILES);
    end
    // frame end flushes and clears the run
    if (e.frame_end) begin
      if (run_size != 0) begin
        res[n] = mk_chunk(run_start, run_size, 1'b0, 1'b0);
        n++;
      end
      run_open  = 1'b0;
      run_start = '0;
      run_size  = '0;
    end
    if (n > 0) begin
      res[n-1].last_of_item = 1'b1;
      res[n-1].frame_done   = e.frame_end;
    end
    return n;
  endfunction

  // mostly contiguous streams, some near misses, jumps and odd counts
  function automatic trcs_in_t random_entry();
    trcs_in_t e;
    int       pick;
    int       cnt;
    pick = $urandom_range(0, 99);
    if (pick < 70 && stream_tile <= 4095)
      e.tile_start = TILE_W'(stream_tile);
    else if (pick < 78 && stream_tile >= 1 && stream_tile <= 4094)
      e.tile_start = TILE_W'(($urandom_range(0, 1) != 0) ? stream_tile + 1 : stream_tile - 1);
    else if (pick < 84)
      e.tile_start = TILE_W'($urandom_range(4060, 4095));
    else
      e.tile_start = TILE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 84)
      cnt = $urandom_range(1, CHUNK_TILES);
    else if (pick < 92)
      cnt = 0;
    else
      cnt = $urandom_range(CHUNK_TILES + 1, 31);
    e.tile_count = COUNT_W'(cnt);
    e.frame_end  = ($urandom_range(0, 9) == 0);
    stream_tile  = e.tile_start + ((cnt > CHUNK_TILES) ? CHUNK_TILES : cnt);
    return e;
  endfunction

  // offer one entry after a random gap and wait for the transaction
  task automatic offer_entry(input trcs_in_t e);
    int gap;
    if (feed_left == 0) begin
      feed_steady = ($urandom_range(0, 2) == 0);
      feed_left   = $urandom_range(8, 40);
    end
    feed_left--;
    gap = feed_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= e;
    do @(posedge clk_i); while (full);
    entries_sent++;
    if (e.frame_end) frame_ends++;
  endtask

  task automatic expect_predicted(input trcs_in_t e);
    trcs_out_t [2:0] res;
    int              n;
    n = coalesce_entry(e, res);
    for (int i = 0; i < n; i++) expected_chunks.push_back(res[i]);
  endtask

  // stimulus and end of run
  initial begin : feed
    dir_row_t        dir_table[$];
    trcs_out_t [2:0] res;
    int              n;
    run_open  = 1'b0;
    run_start = '0;
    run_size  = '0;

    dir_table.push_back(mk_row(0, 16, 1'b0, 1, mk_chunk(0, 16, 1, 0), '0));
    dir_table.push_back(mk_row(16, 0, 1'b1, 0, '0, '0));
    dir_table.push_back(mk_row(4095, 16, 1'b1, 1, mk_chunk(4095, 16, 1, 1), '0));
    dir_table.push_back(mk_row(4095, 31, 1'b0, 1, mk_chunk(4095, 16, 1, 0), '0));
    dir_table.push_back(mk_row(0, 5, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(5, 7, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(12, 9, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(100, 0, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(200, 3, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(300, 15, 1'b1, -1, '0, '0));
    dir_table.push_back(mk_row(10, 10, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(50, 16, 1'b1, -1, '0, '0));
    dir_table.push_back(mk_row(1, 10, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(7, 12, 1'b1, -1, '0, '0));
    dir_table.push_back(mk_row(20, 10, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(30, 10, 1'b1, -1, '0, '0));
    dir_table.push_back(mk_row(2730, 21, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(1365, 10, 1'b1, -1, '0, '0));
    dir_table.push_back(mk_row(4090, 5, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(4095, 1, 1'b0, -1, '0, '0));
    dir_table.push_back(mk_row(0, 1, 1'b1, -1, '0, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_table[i]) begin
      offer_entry(dir_table[i].entry);
      if (dir_table[i].typed) begin
        n = coalesce_entry(dir_table[i].entry, res);
        for (int j = 0; j < dir_table[i].n_typed; j++)
          expected_chunks.push_back(dir_table[i].typed_chunk[j]);
      end else begin
        expect_predicted(dir_table[i].entry);
      end
    end

    // random frames
    for (int i = 0; i < RANDOM_ENTRIES; i++) begin
      trcs_in_t e;
      e = random_entry();
      offer_entry(e);
      expect_predicted(e);
    end
    push <= 1'b0;

    // drain and let the pipeline settle
    while (expected_chunks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d entries with %0d frame ends and %0d checked chunks",
             entries_sent, frame_ends, chunks_checked);
    $display("input held off by full for %0d cycles", full_stalls);
    if (mismatches == 0 && expected_chunks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: random pop gaps, one long hold-off to fill the block
  initial begin : drain
    int        gap;
    int        left;
    bit        steady;
    bit        held;
    trcs_out_t want;
    left = 0;
    steady = 1'b0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && chunks_checked == HOLD_AT) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        left   = $urandom_range(8, 40);
      end
      left--;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      // compare the transaction with the oldest expectation
      if (expected_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected chunk: tile %0d count %0d last %0b done %0b",
                   out_item.chunk_tile, out_item.chunk_count,
                   out_item.last_of_item, out_item.frame_done);
      end else begin
        want = expected_chunks.pop_front();
        if (out_item.chunk_tile !== want.chunk_tile ||
            out_item.chunk_count !== want.chunk_count ||
            out_item.last_of_item !== want.last_of_item ||
            out_item.frame_done !== want.frame_done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("chunk %0d mismatch: expected tile %0d count %0d last %0b done %0b",
                     chunks_checked, want.chunk_tile, want.chunk_count,
                     want.last_of_item, want.frame_done);
            $display("  got tile %0d count %0d last %0b done %0b",
                     out_item.chunk_tile, out_item.chunk_count,
                     out_item.last_of_item, out_item.frame_done);
          end
        end
      end
      chunks_checked++;
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty))
        idle = 0;
      else
        idle++;
      if (push && full) full_stalls++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ tile_run_coalesce_split.f @@
sv/trcs_pkg.sv
sv/trcs_front.sv
sv/trcs_queue.sv
sv/trcs_back.sv
sv/tile_run_coalesce_split.sv
tb/tb.sv
